/* rtl/cfs_pkg.sv */
// shared types, constants and helpers of the command frame serializer
`timescale 1ns / 1ps

package cfs_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ADDR_W        = 5;
    localparam int unsigned PARAM_W       = 32;
    localparam int unsigned LEN_W         = 3;
    localparam int unsigned MAX_PARAM     = 4;
    // start, header and command bytes ahead of the parameter bytes
    localparam int unsigned LEAD_BYTES    = 3;
    localparam int unsigned DATA_BYTES    = LEAD_BYTES + MAX_PARAM;
    localparam int unsigned SHIFT_W       = DATA_BYTES * BYTE_W;
    localparam int unsigned CNT_W         = 3;

    localparam logic [BYTE_W-1:0] FRAME_START    = 8'hFC;
    localparam logic [BYTE_W-1:0] HEADER_NOPARAM = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_MASK      = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;

    // strobes from the top level to the datapath
    typedef struct packed {
        logic load;
        logic shift;
    } cfs_ctl_t;

    // status of the frame shifter
    typedef struct packed {
        logic  busy;
        logic  at_csum;
        byte_t head;
    } cfs_stat_t;

    // clamp the parameter length to the four-byte maximum
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        begin
            if (len > LEN_W'(MAX_PARAM))
            begin
                res = LEN_W'(MAX_PARAM);
            end
            else
            begin
                res = len;
            end
            return res;
        end
    endfunction

    // header byte: length code in the top bits, address in the low five
    function automatic byte_t make_header(input logic [LEN_W-1:0] len,
                                          input logic [ADDR_W-1:0] addr);
        byte_t code;
        begin
            if (len == '0)
            begin
                code = HEADER_NOPARAM;
            end
            else
            begin
                code = BYTE_MASK & byte_t'({len + LEN_W'(1), 5'b0_0000});
            end
            return code | byte_t'(addr);
        end
    endfunction

endpackage

/* rtl/cfs_cmd_if.sv */
// command channel: one actuator command per item
`timescale 1ns / 1ps

interface cfs_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_code;
    logic [4:0]  device_address;
    logic [31:0] parameter_value;
    logic [2:0]  parameter_length;

    modport source (
        output valid, command_code, device_address, parameter_value, parameter_length,
        input  ready
    );
    modport sink (
        input  valid, command_code, device_address, parameter_value, parameter_length,
        output ready
    );
endinterface

/* rtl/cfs_frame_if.sv */
// frame channel: one frame byte per item
`timescale 1ns / 1ps

interface cfs_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (
        output valid, frame_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last_byte,
        output ready
    );
endinterface

/* rtl/cfs_shifter.sv */
// byte shift register holding the data bytes of the current frame
`timescale 1ns / 1ps

module cfs_shifter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfs_pkg::cfs_ctl_t               ctl,
    input  logic [cfs_pkg::BYTE_W-1:0]      command_code,
    input  logic [cfs_pkg::ADDR_W-1:0]      device_address,
    input  logic [cfs_pkg::PARAM_W-1:0]     parameter_value,
    input  logic [cfs_pkg::LEN_W-1:0]       parameter_length,
    output cfs_pkg::cfs_stat_t              stat
);

    logic [cfs_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [cfs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [cfs_pkg::LEN_W-1:0]   len;
    logic [cfs_pkg::PARAM_W-1:0] par_aligned;
    cfs_pkg::byte_t              header;

    // parameter bytes left-aligned so the most significant sent byte leads
    always_comb
    begin
        len    = cfs_pkg::sat_len(parameter_length);
        header = cfs_pkg::make_header(len, device_address);
        case (len)
            3'd1:    par_aligned = {parameter_value[7:0], 24'h0};
            3'd2:    par_aligned = {parameter_value[15:0], 16'h0};
            3'd3:    par_aligned = {parameter_value[23:0], 8'h0};
            3'd4:    par_aligned = parameter_value;
            default: par_aligned = '0;
        endcase
    end

    // load on accept, shift one byte per delivered item
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (ctl.load)
        begin
            shift_next = {cfs_pkg::FRAME_START, header, command_code, par_aligned};
            cnt_next   = cfs_pkg::CNT_W'(cfs_pkg::LEAD_BYTES) + cfs_pkg::CNT_W'(len);
            busy_next  = 1'b1;
        end
        else if (ctl.shift)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = {shift_reg[cfs_pkg::SHIFT_W-cfs_pkg::BYTE_W-1:0],
                              cfs_pkg::BYTE_W'(0)};
                cnt_next   = cnt_reg - cfs_pkg::CNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.at_csum = busy_reg && (cnt_reg == '0);
    assign stat.head    = shift_reg[cfs_pkg::SHIFT_W-1 -: cfs_pkg::BYTE_W];

endmodule

/* rtl/cfs_checksum.sv */
// running 8-bit sum of delivered bytes, complemented for the closing byte
`timescale 1ns / 1ps

module cfs_checksum (
    input  logic               clk,
    input  logic               rst_n,
    input  cfs_pkg::cfs_ctl_t  ctl,
    input  cfs_pkg::cfs_stat_t stat,
    output cfs_pkg::byte_t     csum
);

    cfs_pkg::byte_t sum_reg, sum_next;

    // clear on a new frame, add each data byte as it leaves
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.load)
        begin
            sum_next = '0;
        end
        else if (ctl.shift && !stat.at_csum)
        begin
            sum_next = sum_reg + stat.head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign csum = ~sum_reg;

endmodule

/* rtl/command_frame_serializer_top.sv */
// top level of the command frame serializer
//
//  channel  | dir | payload                                            | unit
//  ---------+-----+----------------------------------------------------+-------------
//  command  | in  | command_code, device_address, parameter_value,     | one command
//           |     | parameter_length                                   |
//  frame    | out | frame_byte, last_byte                              | one byte
//
// a command yields 4 to 8 bytes (parameter_length clamped to 4) from the byte
// shift register, one per cycle unless frame stalls; a new command is taken in the
// cycle its frame's last byte is taken; the first byte follows the accept edge.
// reset clears the busy flag and the byte counter; the shift register is not reset.
// a stall on frame holds the current byte and the running sum.
`timescale 1ns / 1ps

module command_frame_serializer_top (
    input  logic        clk,
    input  logic        rst_n,
    cfs_cmd_if.sink     command,
    cfs_frame_if.source frame
);

    cfs_pkg::cfs_ctl_t  ctl;
    cfs_pkg::cfs_stat_t stat;
    cfs_pkg::byte_t     csum;

    // handshakes
    assign command.ready = !stat.busy || (frame.ready && stat.at_csum);
    assign ctl.load      = command.valid && command.ready;
    assign ctl.shift     = stat.busy && frame.ready;

    cfs_shifter u_shifter (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .command_code     (command.command_code),
        .device_address   (command.device_address),
        .parameter_value  (command.parameter_value),
        .parameter_length (command.parameter_length),
        .stat             (stat)
    );

    cfs_checksum u_checksum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .csum  (csum)
    );

    // output byte: shifter head, or the checksum at frame end
    assign frame.valid      = stat.busy;
    assign frame.last_byte  = stat.at_csum;
    assign frame.frame_byte = stat.at_csum ? csum : stat.head;

endmodule
